// File: rtl/core/tonu_pkg.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator package
// Protocol codes, result kinds, job descriptor and sequencing helpers.
// ----------------------------------------------------------------------------
package tonu_pkg;

  // Telnet protocol bytes
  localparam logic [7:0] TEL_IAC        = 8'd255;
  localparam logic [7:0] TEL_SE         = 8'd240;
  localparam logic [7:0] TEL_SB         = 8'd250;
  localparam logic [7:0] TEL_WILL       = 8'd251;
  localparam logic [7:0] TEL_WONT       = 8'd252;
  localparam logic [7:0] TEL_DO         = 8'd253;
  localparam logic [7:0] TEL_DONT       = 8'd254;
  localparam logic [7:0] OPT_NAWS       = 8'd31;
  localparam logic [7:0] OPT_SPEED      = 8'd32;
  localparam logic [7:0] TEL_SUB_SEND   = 8'd1;
  localparam logic [7:0] SPEED_TXT_MARK = 8'd0;

  // Result kinds
  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_SEND     = 3'd1;
  localparam logic [2:0] KIND_WINSIZE  = 3'd2;
  localparam logic [2:0] KIND_SPEED    = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN  = 3'd4;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CMD,
    PH_OPT,
    PH_SUB
  } phase_e;

  // Jobs handed from the parser to the result sequencer
  typedef enum logic [2:0] {
    OP_DATA,       // one data byte
    OP_SEND3,      // IAC, b0, b1
    OP_SPEED_REQ,  // IAC DO 32 IAC SB 32 1 IAC SE
    OP_WINSIZE,    // window size report
    OP_SPEED_TXT,  // one speed text byte
    OP_UNKNOWN     // unknown command report
  } job_op_e;

  typedef struct packed {
    job_op_e     op;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] w;
    logic [15:0] h;
  } job_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int SEQ_W  = 4;

  // Number of results a job expands into
  function automatic logic [SEQ_W-1:0] job_len(job_op_e op);
    logic [SEQ_W-1:0] len;
    unique case (op)
      OP_SEND3:     len = SEQ_W'(3);
      OP_SPEED_REQ: len = SEQ_W'(9);
      default:      len = SEQ_W'(1);
    endcase
    return len;
  endfunction

  // Byte sequence of the speed request answer
  function automatic logic [7:0] speed_req_byte(logic [SEQ_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      SEQ_W'(0): b = TEL_IAC;
      SEQ_W'(1): b = TEL_DO;
      SEQ_W'(2): b = OPT_SPEED;
      SEQ_W'(3): b = TEL_IAC;
      SEQ_W'(4): b = TEL_SB;
      SEQ_W'(5): b = OPT_SPEED;
      SEQ_W'(6): b = TEL_SUB_SEND;
      SEQ_W'(7): b = TEL_IAC;
      SEQ_W'(8): b = TEL_SE;
      default:   b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/tonu_front.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator parser
// Accepts one byte per cycle while accept_i is high, tracks the command phase and emits jobs.
// ----------------------------------------------------------------------------
module tonu_front
  import tonu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output job_t       job_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  opt_q, opt_d;
  logic [2:0]  sub_cnt_q, sub_cnt_d;
  logic [31:0] size_q, size_d;
  logic [7:0]  held_q, held_d;
  logic        held_vld_q, held_vld_d;
  logic        speed_q, speed_d;
  logic [31:0] size_merge;
  logic        is_se;

  assign is_se = (rx_byte_i == TEL_SE);

  // current byte merged into the size word while fewer than four collected
  always_comb begin
    size_merge = size_q;
    if (!sub_cnt_q[2]) begin
      case (sub_cnt_q[1:0])
        2'd0:    size_merge[31:24] = rx_byte_i;
        2'd1:    size_merge[23:16] = rx_byte_i;
        2'd2:    size_merge[15:8]  = rx_byte_i;
        default: size_merge[7:0]   = rx_byte_i;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_DATA: if (rx_byte_i == TEL_IAC) phase_d = PH_CMD;
        PH_CMD:  phase_d = PH_OPT;
        PH_OPT:  phase_d = (cmd_q == TEL_SB) ? PH_SUB : PH_DATA;
        PH_SUB:  if (is_se) phase_d = PH_DATA;
        default: phase_d = PH_DATA;
      endcase
    end
  end

  // jobs and data state
  always_comb begin
    cmd_d      = cmd_q;
    opt_d      = opt_q;
    sub_cnt_d  = sub_cnt_q;
    size_d     = size_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    speed_d    = speed_q;
    push_o     = 1'b0;
    job_o      = '0;
    if (accept_i) begin
      unique case (phase_q)
        PH_DATA: begin
          if (rx_byte_i != TEL_IAC) begin
            push_o   = 1'b1;
            job_o.op = OP_DATA;
            job_o.b0 = rx_byte_i;
          end
        end
        PH_CMD: begin
          cmd_d = rx_byte_i;
        end
        PH_OPT: begin
          opt_d = rx_byte_i;
          if (cmd_q == TEL_WILL) begin
            push_o = 1'b1;
            if (rx_byte_i == OPT_SPEED) begin
              job_o.op = OP_SPEED_REQ;
            end else begin
              job_o.op = OP_SEND3;
              job_o.b0 = (rx_byte_i == OPT_NAWS) ? TEL_DO : TEL_DONT;
              job_o.b1 = rx_byte_i;
            end
          end else if (cmd_q == TEL_DO) begin
            push_o   = 1'b1;
            job_o.op = OP_SEND3;
            job_o.b0 = TEL_WONT;
            job_o.b1 = rx_byte_i;
          end else if (cmd_q == TEL_WONT || cmd_q == TEL_DONT) begin
            push_o = 1'b0;
          end else if (cmd_q == TEL_SB) begin
            sub_cnt_d  = '0;
            size_d     = '0;
            held_d     = '0;
            held_vld_d = 1'b0;
            speed_d    = 1'b0;
          end else begin
            push_o   = 1'b1;
            job_o.op = OP_UNKNOWN;
            job_o.b0 = cmd_q;
            job_o.b1 = rx_byte_i;
          end
        end
        PH_SUB: begin
          if (!sub_cnt_q[2]) begin
            size_d    = size_merge;
            sub_cnt_d = sub_cnt_q + 3'd1;
          end
          if (is_se) begin
            if (opt_q == OPT_NAWS) begin
              push_o   = 1'b1;
              job_o.op = OP_WINSIZE;
              job_o.w  = size_merge[31:16];
              job_o.h  = size_merge[15:0];
            end
            held_vld_d = 1'b0;
            speed_d    = 1'b0;
          end else if (sub_cnt_q == 3'd0) begin
            speed_d = (opt_q == OPT_SPEED) && (rx_byte_i == SPEED_TXT_MARK);
          end else begin
            if (speed_q && held_vld_q) begin
              push_o   = 1'b1;
              job_o.op = OP_SPEED_TXT;
              job_o.b0 = held_q;
            end
            held_d     = rx_byte_i;
            held_vld_d = 1'b1;
          end
        end
        default: push_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DATA;
      cmd_q      <= '0;
      opt_q      <= '0;
      sub_cnt_q  <= '0;
      size_q     <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      speed_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cmd_q      <= cmd_d;
      opt_q      <= opt_d;
      sub_cnt_q  <= sub_cnt_d;
      size_q     <= size_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      speed_q    <= speed_d;
    end
  end

endmodule

// File: rtl/core/tonu_queue.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator job queue
// Small register FIFO between parser and result sequencer.
// ----------------------------------------------------------------------------
module tonu_queue
  import tonu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t head_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + QCNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job queue underflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH)) else $error("job queue count out of range");

endmodule

// File: rtl/core/tonu_back.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator result sequencer
// Expands queued jobs into result transfers through an output register.
// ----------------------------------------------------------------------------
module tonu_back
  import tonu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_vld_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [7:0]  option_code_o,
  output logic [15:0] width_o,
  output logic [15:0] height_o,
  output logic        last_o
);

  logic [SEQ_W-1:0] idx_q, idx_d;
  logic             vld_q;
  logic [2:0]       kind_q, kind_d;
  logic [7:0]       byte_q, byte_d;
  logic [7:0]       opt_q, opt_d;
  logic [15:0]      w_q, w_d;
  logic [15:0]      h_q, h_d;
  logic             last_q, last_d;
  logic             load, emit;

  assign load  = !vld_q || out_ready_i;
  assign emit  = head_vld_i && load;
  assign last_d = (idx_q == job_len(head_i.op) - SEQ_W'(1));
  assign pop_o = emit && last_d;
  assign idx_d = pop_o ? '0 : (emit ? idx_q + SEQ_W'(1) : idx_q);

  always_comb begin
    kind_d = KIND_DATA;
    byte_d = head_i.b0;
    opt_d  = '0;
    w_d    = '0;
    h_d    = '0;
    unique case (head_i.op)
      OP_DATA: kind_d = KIND_DATA;
      OP_SEND3: begin
        kind_d = KIND_SEND;
        if (idx_q == SEQ_W'(0))      byte_d = TEL_IAC;
        else if (idx_q == SEQ_W'(1)) byte_d = head_i.b0;
        else                         byte_d = head_i.b1;
      end
      OP_SPEED_REQ: begin
        kind_d = KIND_SEND;
        byte_d = speed_req_byte(idx_q);
      end
      OP_WINSIZE: begin
        kind_d = KIND_WINSIZE;
        byte_d = '0;
        w_d    = head_i.w;
        h_d    = head_i.h;
      end
      OP_SPEED_TXT: kind_d = KIND_SPEED;
      OP_UNKNOWN: begin
        kind_d = KIND_UNKNOWN;
        opt_d  = head_i.b1;
      end
      default: kind_d = KIND_DATA;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) vld_q <= head_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      opt_q  <= opt_d;
      w_q    <= w_d;
      h_q    <= h_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = vld_q;
  assign kind_o        = kind_q;
  assign byte_value_o  = byte_q;
  assign option_code_o = opt_q;
  assign width_o       = w_q;
  assign height_o      = h_q;
  assign last_o        = last_q;

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == '0) else $error("sequence index not restarted");

endmodule

// File: rtl/core/telnet_option_negotiator_unit.sv
// Path: with the queue empty and the output register free, the accepting edge writes a
//   byte's job into the job queue, and a later edge loads its first result from the
//   queue head into the output register, which drives out_valid_o.
// Throughput: one byte accepted per cycle while the job queue has room and one result
//   transfer per cycle while out_ready_i is high; a WILL 32 answer expands into nine transfers.
// Reset: asynchronous, active low; clears parser phase, job queue and output valid.
// ----------------------------------------------------------------------------
// Telnet option negotiator
// Parses the client byte stream, answers option requests and reports
// data, window size, speed text and unknown commands.
// ----------------------------------------------------------------------------
module telnet_option_negotiator_unit
  import tonu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [7:0]  option_code_o,
  output logic [15:0] width_o,
  output logic [15:0] height_o,
  output logic        last_o
);

  // Front: the parser takes a byte whenever the job queue has room, so it
  // never waits for the output side unless four jobs are already pending.
  // Bytes that give no result (IAC, command, WONT/DONT, silent
  // subnegotiation bytes) only update parser state and push nothing.
  logic accept;
  logic push, pop, full, empty;
  job_t job, head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  tonu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .job_o     (job)
  );

  // Queue: a job is one compact descriptor; the back end expands it into
  // one to nine result transfers, so bursts stay out of the parser's way.
  tonu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // Back: sequencer walks the head job one result per transfer; the
  // output register reloads in the same cycle it is drained.
  tonu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_vld_i    (!empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .byte_value_o  (byte_value_o),
    .option_code_o (option_code_o),
    .width_o       (width_o),
    .height_o      (height_o),
    .last_o        (last_o)
  );

endmodule
